@@ rtl/assert_macros.svh @@
// Assertion macros for use by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("lbl failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("lbl failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ rtl/z80d_pkg.sv @@
// ----------------------------------------------------------------------------
// z80d_pkg
// Types, class codes and the base opcode decode for the instruction decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package z80d_pkg;

    localparam logic [3:0] F_IMM = 4'd1;
    localparam logic [3:0] F_MEM = 4'd2;
    localparam logic [3:0] F_ADR = 4'd4;
    localparam logic [3:0] F_PFX = 4'd8;

    localparam logic [7:0] OP_CB   = 8'hcb;
    localparam logic [7:0] OP_ED   = 8'hed;
    localparam logic [7:0] OP_DD   = 8'hdd;
    localparam logic [7:0] OP_FD   = 8'hfd;
    localparam logic [7:0] OP_HOOK = 8'hfe;
    localparam logic [7:0] OP_HLT  = 8'h76;
    localparam logic [7:0] HOOK_LIMIT_RESET = 8'hff;

    typedef enum logic [5:0] {
        C_NOP, C_LDRR, C_LDRI, C_ALU, C_INR, C_DCR, C_LXI, C_DAD, C_INX, C_DCX,
        C_LDAX, C_STAX, C_LDA, C_STA, C_LHLD, C_SHLD, C_ROT, C_DAA, C_CMA, C_STC,
        C_CMC, C_JMP, C_JCC, C_CALL, C_CCC, C_RET, C_RCC, C_RST, C_PCHL, C_SPHL,
        C_XTHL, C_XCHG, C_PUSH, C_POP, C_IN, C_OUT, C_EI, C_DI, C_HLT, C_JR,
        C_DJNZ, C_EXAF, C_EXX, C_CB, C_ED, C_IX, C_IXCB, C_HOOK, C_BAD
    } op_class_t;

    typedef struct packed {
        op_class_t  cls;
        logic [2:0] fx;
        logic [2:0] fy;
        logic [3:0] fl;
        logic [2:0] len;
    } base_dec_t;

    typedef struct packed {
        logic [15:0] fetch_pc;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
    } in_item_t;

    typedef struct packed {
        logic [5:0]        op_class;
        logic [7:0]        field_x;
        logic [2:0]        field_y;
        logic [3:0]        flags;
        logic [2:0]        length;
        logic [7:0]        prefix_byte;
        logic [7:0]        sub_byte;
        logic [15:0]       immediate;
        logic signed [7:0] displacement;
    } out_item_t;

    function automatic base_dec_t decode_base(input logic [7:0] op);
        base_dec_t  d;
        logic [1:0] x;
        logic [2:0] y;
        logic [2:0] z;
        logic [1:0] p;
        logic       q;
        x = op[7:6];
        y = op[5:3];
        z = op[2:0];
        p = y[2:1];
        q = y[0];
        d.cls = C_NOP;
        d.fx = 3'd0;
        d.fy = 3'd0;
        d.fl = 4'd0;
        d.len = 3'd1;
        unique case (x)
            2'd0:
            begin
                unique case (z)
                    3'd0:
                    begin
                        if (y == 3'd0) d.cls = C_NOP;
                        else if (y == 3'd1) d.cls = C_EXAF;
                        else if (y == 3'd2)
                        begin
                            d.cls = C_DJNZ;
                            d.len = 3'd2;
                        end
                        else
                        begin
                            d.cls = C_JR;
                            d.len = 3'd2;
                            d.fx = (y == 3'd3) ? 3'd4 : y - 3'd4;
                        end
                    end
                    3'd1:
                    begin
                        d.fx = {1'b0, p};
                        if (!q)
                        begin
                            d.cls = C_LXI;
                            d.fl = F_IMM;
                            d.len = 3'd3;
                        end
                        else d.cls = C_DAD;
                    end
                    3'd2:
                    begin
                        if (!p[1])
                        begin
                            d.cls = q ? C_LDAX : C_STAX;
                            d.fx = {1'b0, p};
                            d.fl = F_MEM;
                        end
                        else
                        begin
                            if (p == 2'd2) d.cls = q ? C_LHLD : C_SHLD;
                            else d.cls = q ? C_LDA : C_STA;
                            d.fl = F_IMM | F_MEM | F_ADR;
                            d.len = 3'd3;
                        end
                    end
                    3'd3:
                    begin
                        d.cls = q ? C_DCX : C_INX;
                        d.fx = {1'b0, p};
                    end
                    3'd4, 3'd5:
                    begin
                        d.cls = (z == 3'd4) ? C_INR : C_DCR;
                        d.fx = y;
                        if (y == 3'd6) d.fl = F_MEM;
                    end
                    3'd6:
                    begin
                        d.cls = C_LDRI;
                        d.fx = y;
                        d.len = 3'd2;
                        d.fl = F_IMM | ((y == 3'd6) ? F_MEM : 4'd0);
                    end
                    default:
                    begin
                        if (!y[2])
                        begin
                            d.cls = C_ROT;
                            d.fx = y;
                        end
                        else
                        begin
                            unique case (y[1:0])
                                2'd0: d.cls = C_DAA;
                                2'd1: d.cls = C_CMA;
                                2'd2: d.cls = C_STC;
                                default: d.cls = C_CMC;
                            endcase
                        end
                    end
                endcase
            end
            2'd1:
            begin
                if (op == OP_HLT) d.cls = C_HLT;
                else
                begin
                    d.cls = C_LDRR;
                    d.fx = y;
                    d.fy = z;
                    if (y == 3'd6 || z == 3'd6) d.fl = F_MEM;
                end
            end
            2'd2:
            begin
                d.cls = C_ALU;
                d.fx = y;
                d.fy = z;
                if (z == 3'd6) d.fl = F_MEM;
            end
            default:
            begin
                unique case (z)
                    3'd0:
                    begin
                        d.cls = C_RCC;
                        d.fx = y;
                    end
                    3'd1:
                    begin
                        if (!q)
                        begin
                            d.cls = C_POP;
                            d.fx = {1'b0, p};
                        end
                        else
                        begin
                            unique case (p)
                                2'd0: d.cls = C_RET;
                                2'd1: d.cls = C_EXX;
                                2'd2: d.cls = C_PCHL;
                                default: d.cls = C_SPHL;
                            endcase
                        end
                    end
                    3'd2:
                    begin
                        d.cls = C_JCC;
                        d.fx = y;
                        d.fl = F_ADR;
                        d.len = 3'd3;
                    end
                    3'd3:
                    begin
                        unique case (y)
                            3'd0:
                            begin
                                d.cls = C_JMP;
                                d.fl = F_ADR;
                                d.len = 3'd3;
                            end
                            3'd1:
                            begin
                                d.cls = C_CB;
                                d.fl = F_PFX;
                            end
                            3'd2:
                            begin
                                d.cls = C_OUT;
                                d.len = 3'd2;
                            end
                            3'd3:
                            begin
                                d.cls = C_IN;
                                d.len = 3'd2;
                            end
                            3'd4:
                            begin
                                d.cls = C_XTHL;
                                d.fl = F_MEM;
                            end
                            3'd5: d.cls = C_XCHG;
                            3'd6: d.cls = C_DI;
                            default: d.cls = C_EI;
                        endcase
                    end
                    3'd4:
                    begin
                        d.cls = C_CCC;
                        d.fx = y;
                        d.fl = F_ADR;
                        d.len = 3'd3;
                    end
                    3'd5:
                    begin
                        if (!q)
                        begin
                            d.cls = C_PUSH;
                            d.fx = {1'b0, p};
                        end
                        else if (p == 2'd0)
                        begin
                            d.cls = C_CALL;
                            d.fl = F_ADR;
                            d.len = 3'd3;
                        end
                        else
                        begin
                            d.cls = (p == 2'd2) ? C_ED : C_IX;
                            d.fl = F_PFX;
                        end
                    end
                    3'd6:
                    begin
                        d.cls = C_ALU;
                        d.fx = y;
                        d.fl = F_IMM;
                        d.len = 3'd2;
                    end
                    default:
                    begin
                        d.cls = C_RST;
                        d.fx = y;
                    end
                endcase
            end
        endcase
        return d;
    endfunction

    function automatic logic names_hl_memory(input logic [7:0] op);
        logic r;
        r = 1'b0;
        if (op == 8'h34 || op == 8'h35 || op == 8'h36) r = 1'b1;
        else if (op >= 8'h70 && op <= 8'h77) r = (op != OP_HLT);
        else if (op >= 8'h40 && op <= 8'hbf) r = (op[2:0] == 3'd6);
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/z80d_if.sv @@
// ----------------------------------------------------------------------------
// z80d_in_if / z80d_out_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface z80d_in_if;
    logic              valid;
    logic              ready;
    z80d_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface z80d_out_if;
    logic               valid;
    logic               ready;
    z80d_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/z80_instruction_decoder_top.sv @@
// Pipeline: three register stages; an accepted item is registered in stage 1,
// then in stage 2, then in stage 3, from which the result is presented.
// Throughput: one item per cycle; the three stages advance together and
// hold as a whole when the output is stalled and full.
// Reset: all stage valid bits clear; hook_limit returns to 255.
// ----------------------------------------------------------------------------
// z80_instruction_decoder_top
// Three-stage decode of one 8080/Z80 instruction window per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module z80_instruction_decoder_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    z80d_in_if.sink         in_ch,
    z80d_out_if.source      out_ch
);

    logic [7:0] hook_limit_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic adv;

    // stage 1: raw item and base decodes
    z80d_pkg::in_item_t   s1_reg;
    z80d_pkg::base_dec_t  d0_reg, d0_next;
    z80d_pkg::base_dec_t  d1_reg, d1_next;
    logic                 hl1_reg, hl1_next;

    // stage 2: partial result and jump target operands
    z80d_pkg::out_item_t  s2_reg, s2_next;
    logic                 jr2_reg, jr2_next;
    logic [15:0]          pc2_reg;
    logic [7:0]           b2_reg;

    z80d_pkg::out_item_t  s3_reg, s3_next;

    assign adv = !v3_reg || out_ch.ready;
    assign in_ch.ready = adv;
    assign out_ch.valid = v3_reg;
    assign out_ch.data = s3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hook_limit_reg <= z80d_pkg::HOOK_LIMIT_RESET;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we) hook_limit_reg <= cfg_wdata;
            if (adv)
            begin
                v1_reg <= in_ch.valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    always_comb
    begin
        d0_next = z80d_pkg::decode_base(in_ch.data.byte0);
        d1_next = z80d_pkg::decode_base(in_ch.data.byte1);
        hl1_next = z80d_pkg::names_hl_memory(in_ch.data.byte1);
    end

    always_comb
    begin
        logic [7:0] b0, b1, b2, b3;
        b0 = s1_reg.byte0;
        b1 = s1_reg.byte1;
        b2 = s1_reg.byte2;
        b3 = s1_reg.byte3;
        s2_next = '0;
        jr2_next = 1'b0;
        if ((d0_reg.fl & z80d_pkg::F_PFX) == 4'd0)
        begin
            s2_next.op_class = d0_reg.cls;
            s2_next.field_x = {5'd0, d0_reg.fx};
            s2_next.field_y = d0_reg.fy;
            s2_next.flags = d0_reg.fl;
            s2_next.length = d0_reg.len;
            if (d0_reg.len == 3'd3) s2_next.immediate = {b2, b1};
            else if (d0_reg.len == 3'd2)
            begin
                if (d0_reg.cls == z80d_pkg::C_JR || d0_reg.cls == z80d_pkg::C_DJNZ)
                    jr2_next = 1'b1;
                else s2_next.immediate = {8'd0, b1};
            end
        end
        else
        begin
            s2_next.prefix_byte = b0;
            s2_next.sub_byte = b1;
            s2_next.flags = z80d_pkg::F_PFX;
            if (b0 == z80d_pkg::OP_CB)
            begin
                s2_next.op_class = z80d_pkg::C_CB;
                s2_next.length = 3'd2;
                s2_next.field_x = {6'd0, b1[7:6]};
                s2_next.field_y = b1[2:0];
                s2_next.immediate = {13'd0, b1[5:3]};
                if (b1[2:0] == 3'd6) s2_next.flags = z80d_pkg::F_PFX | z80d_pkg::F_MEM;
            end
            else if (b0 == z80d_pkg::OP_ED)
            begin
                if (b1 == z80d_pkg::OP_HOOK)
                begin
                    s2_next.field_x = b2;
                    s2_next.length = 3'd3;
                    s2_next.op_class = (b2 > hook_limit_reg) ? z80d_pkg::C_BAD
                                                             : z80d_pkg::C_HOOK;
                end
                else
                begin
                    s2_next.op_class = z80d_pkg::C_ED;
                    s2_next.length = 3'd2;
                    if (b1[7:6] == 2'b01 && b1[2:0] == 3'd3)
                    begin
                        s2_next.length = 3'd4;
                        s2_next.field_x = {6'd0, b1[5:4]};
                        s2_next.immediate = {b3, b2};
                        s2_next.flags = 4'hf;
                    end
                end
            end
            else
            begin
                s2_next.op_class = z80d_pkg::C_IX;
                if (b1 == z80d_pkg::OP_DD || b1 == z80d_pkg::OP_FD
                    || b1 == z80d_pkg::OP_ED)
                    s2_next.length = 3'd1;
                else if (b1 == z80d_pkg::OP_CB)
                begin
                    s2_next.op_class = z80d_pkg::C_IXCB;
                    s2_next.length = 3'd4;
                    s2_next.displacement = b2;
                end
                else
                begin
                    s2_next.length = 3'd1 + d1_reg.len + {2'd0, hl1_reg};
                    if (hl1_reg) s2_next.displacement = b2;
                end
            end
        end
    end

    always_comb
    begin
        s3_next = s2_reg;
        if (jr2_reg)
            s3_next.immediate = pc2_reg + 16'd2 + {{8{b2_reg[7]}}, b2_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= in_ch.data;
            d0_reg <= d0_next;
            d1_reg <= d1_next;
            hl1_reg <= hl1_next;
            s2_reg <= s2_next;
            jr2_reg <= jr2_next;
            pc2_reg <= s1_reg.fetch_pc;
            b2_reg <= s1_reg.byte1;
            s3_reg <= s3_next;
        end
    end

    `ASSERT_CLK(a_hold_out, clk, rst_n, (v3_reg && !out_ch.ready) |=> (v3_reg && $stable(s3_reg)))
    `ASSERT_NEVER(a_len_zero, clk, rst_n, v3_reg && s3_reg.length == 3'd0)
    `ASSERT_CLK(a_adv_move, clk, rst_n, (adv && v2_reg) |=> v3_reg)

endmodule
`default_nettype wire

@@ dv/tb_z80_instruction_decoder_top.sv @@
// ----------------------------------------------------------------------------
// tb_z80_instruction_decoder_top
// Drives instruction windows into the decoder with random gaps and output
// stalls, predicts each decoded result and checks it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class decode_scoreboard;
    z80d_pkg::out_item_t pending[$];
    bit failed;

    function void note_item(z80d_pkg::out_item_t exp_item);
        pending.push_back(exp_item);
    endfunction

    function void check_result(z80d_pkg::out_item_t got);
        z80d_pkg::out_item_t exp_item;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result %h", $realtime, got);
            failed = 1;
            return;
        end
        exp_item = pending.pop_front();
        if (got.op_class != exp_item.op_class)
        begin
            $display("%0t: op_class exp %0d got %0d", $realtime, exp_item.op_class, got.op_class);
            failed = 1;
        end
        if (got.field_x != exp_item.field_x)
        begin
            $display("%0t: field_x exp %h got %h", $realtime, exp_item.field_x, got.field_x);
            failed = 1;
        end
        if (got.field_y != exp_item.field_y)
        begin
            $display("%0t: field_y exp %h got %h", $realtime, exp_item.field_y, got.field_y);
            failed = 1;
        end
        if (got.flags != exp_item.flags)
        begin
            $display("%0t: flags exp %h got %h", $realtime, exp_item.flags, got.flags);
            failed = 1;
        end
        if (got.length != exp_item.length)
        begin
            $display("%0t: length exp %0d got %0d", $realtime, exp_item.length, got.length);
            failed = 1;
        end
        if (got.prefix_byte != exp_item.prefix_byte)
        begin
            $display("%0t: prefix_byte exp %h got %h", $realtime, exp_item.prefix_byte,
                     got.prefix_byte);
            failed = 1;
        end
        if (got.sub_byte != exp_item.sub_byte)
        begin
            $display("%0t: sub_byte exp %h got %h", $realtime, exp_item.sub_byte, got.sub_byte);
            failed = 1;
        end
        if (got.immediate != exp_item.immediate)
        begin
            $display("%0t: immediate exp %h got %h", $realtime, exp_item.immediate,
                     got.immediate);
            failed = 1;
        end
        if (got.displacement != exp_item.displacement)
        begin
            $display("%0t: displacement exp %h got %h", $realtime, exp_item.displacement,
                     got.displacement);
            failed = 1;
        end
    endfunction
endclass

module tb_z80_instruction_decoder_top;
    import z80d_pkg::*;

    typedef struct {
        op_class_t  cls;
        logic [7:0] fx;
        logic [2:0] fy;
        logic [3:0] fl;
        logic [2:0] len;
    } opcode_info_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    logic [7:0] exp_hook_limit;
    bit         out_ready_en;
    decode_scoreboard sb;

    z80d_in_if  in_ch ();
    z80d_out_if out_ch ();

    z80_instruction_decoder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    always #2 clk = ~clk;

    function automatic opcode_info_t opcode_info(logic [7:0] op);
        opcode_info_t d;
        logic [1:0] x;
        logic [2:0] y;
        logic [2:0] z;
        logic [1:0] p;
        logic       q;
        x = op[7:6];
        y = op[5:3];
        z = op[2:0];
        p = y[2:1];
        q = y[0];
        d.cls = C_NOP;
        d.fx = 8'd0;
        d.fy = 3'd0;
        d.fl = 4'd0;
        d.len = 3'd1;
        if (x == 0)
        begin
            case (z)
                0:
                begin
                    if (y == 0) d.cls = C_NOP;
                    else if (y == 1) d.cls = C_EXAF;
                    else if (y == 2)
                    begin
                        d.cls = C_DJNZ;
                        d.len = 2;
                    end
                    else
                    begin
                        d.cls = C_JR;
                        d.len = 2;
                        d.fx = (y == 3) ? 8'd4 : 8'(y - 3'd4);
                    end
                end
                1:
                begin
                    d.fx = {6'd0, p};
                    if (q == 0)
                    begin
                        d.cls = C_LXI;
                        d.fl = F_IMM;
                        d.len = 3;
                    end
                    else d.cls = C_DAD;
                end
                2:
                begin
                    if (p < 2)
                    begin
                        d.cls = q ? C_LDAX : C_STAX;
                        d.fx = {6'd0, p};
                        d.fl = F_MEM;
                    end
                    else
                    begin
                        if (p == 2) d.cls = q ? C_LHLD : C_SHLD;
                        else d.cls = q ? C_LDA : C_STA;
                        d.fl = F_IMM | F_MEM | F_ADR;
                        d.len = 3;
                    end
                end
                3:
                begin
                    d.cls = q ? C_DCX : C_INX;
                    d.fx = {6'd0, p};
                end
                4, 5:
                begin
                    d.cls = (z == 4) ? C_INR : C_DCR;
                    d.fx = {5'd0, y};
                    if (y == 6) d.fl = F_MEM;
                end
                6:
                begin
                    d.cls = C_LDRI;
                    d.fx = {5'd0, y};
                    d.len = 2;
                    d.fl = F_IMM | ((y == 6) ? F_MEM : 4'd0);
                end
                default:
                begin
                    d.fx = (y < 4) ? 8'(y) : 8'd0;
                    case (y)
                        4: d.cls = C_DAA;
                        5: d.cls = C_CMA;
                        6: d.cls = C_STC;
                        7: d.cls = C_CMC;
                        default: d.cls = C_ROT;
                    endcase
                end
            endcase
        end
        else if (x == 1)
        begin
            if (op == OP_HLT) d.cls = C_HLT;
            else
            begin
                d.cls = C_LDRR;
                d.fx = {5'd0, y};
                d.fy = z;
                if (y == 6 || z == 6) d.fl = F_MEM;
            end
        end
        else if (x == 2)
        begin
            d.cls = C_ALU;
            d.fx = {5'd0, y};
            d.fy = z;
            if (z == 6) d.fl = F_MEM;
        end
        else
        begin
            case (z)
                0:
                begin
                    d.cls = C_RCC;
                    d.fx = {5'd0, y};
                end
                1:
                begin
                    if (q == 0)
                    begin
                        d.cls = C_POP;
                        d.fx = {6'd0, p};
                    end
                    else
                    begin
                        case (p)
                            0: d.cls = C_RET;
                            1: d.cls = C_EXX;
                            2: d.cls = C_PCHL;
                            default: d.cls = C_SPHL;
                        endcase
                    end
                end
                2, 4:
                begin
                    d.cls = (z == 2) ? C_JCC : C_CCC;
                    d.fx = {5'd0, y};
                    d.fl = F_ADR;
                    d.len = 3;
                end
                3:
                begin
                    case (y)
                        0:
                        begin
                            d.cls = C_JMP;
                            d.fl = F_ADR;
                            d.len = 3;
                        end
                        1:
                        begin
                            d.cls = C_CB;
                            d.fl = F_PFX;
                        end
                        2:
                        begin
                            d.cls = C_OUT;
                            d.len = 2;
                        end
                        3:
                        begin
                            d.cls = C_IN;
                            d.len = 2;
                        end
                        4:
                        begin
                            d.cls = C_XTHL;
                            d.fl = F_MEM;
                        end
                        5: d.cls = C_XCHG;
                        6: d.cls = C_DI;
                        default: d.cls = C_EI;
                    endcase
                end
                5:
                begin
                    if (q == 0)
                    begin
                        d.cls = C_PUSH;
                        d.fx = {6'd0, p};
                    end
                    else if (p == 0)
                    begin
                        d.cls = C_CALL;
                        d.fl = F_ADR;
                        d.len = 3;
                    end
                    else
                    begin
                        d.cls = (p == 2) ? C_ED : C_IX;
                        d.fl = F_PFX;
                    end
                end
                6:
                begin
                    d.cls = C_ALU;
                    d.fx = {5'd0, y};
                    d.fl = F_IMM;
                    d.len = 2;
                end
                default:
                begin
                    d.cls = C_RST;
                    d.fx = {5'd0, y};
                end
            endcase
        end
        return d;
    endfunction

    function automatic bit uses_hl_memory(logic [7:0] op);
        if (op inside {8'h34, 8'h35, 8'h36}) return 1;
        if (op >= 8'h70 && op <= 8'h77) return op != OP_HLT;
        if (op >= 8'h40 && op <= 8'hbf) return op[2:0] == 3'd6;
        return 0;
    endfunction

    function automatic out_item_t decode_window(in_item_t w);
        out_item_t    r;
        opcode_info_t d;
        opcode_info_t s;
        d = opcode_info(w.byte0);
        r = '0;
        if (!d.fl[3])
        begin
            r.op_class = d.cls;
            r.field_x = d.fx;
            r.field_y = d.fy;
            r.flags = d.fl;
            r.length = d.len;
            if (d.len == 3) r.immediate = {w.byte2, w.byte1};
            else if (d.len == 2)
            begin
                if (d.cls == C_JR || d.cls == C_DJNZ)
                    r.immediate = w.fetch_pc + 16'd2 + {{8{w.byte1[7]}}, w.byte1};
                else r.immediate = {8'd0, w.byte1};
            end
        end
        else
        begin
            r.prefix_byte = w.byte0;
            r.sub_byte = w.byte1;
            r.flags = F_PFX;
            if (w.byte0 == OP_CB)
            begin
                r.op_class = C_CB;
                r.length = 2;
                r.field_x = {6'd0, w.byte1[7:6]};
                r.field_y = w.byte1[2:0];
                r.immediate = {13'd0, w.byte1[5:3]};
                if (w.byte1[2:0] == 3'd6) r.flags |= F_MEM;
            end
            else if (w.byte0 == OP_ED)
            begin
                if (w.byte1 == OP_HOOK)
                begin
                    r.field_x = w.byte2;
                    r.length = 3;
                    r.op_class = (w.byte2 > exp_hook_limit) ? C_BAD : C_HOOK;
                end
                else
                begin
                    r.op_class = C_ED;
                    r.length = 2;
                    if ((w.byte1 & 8'hc7) == 8'h43 && w.byte1 >= 8'h40 && w.byte1 <= 8'h7f)
                    begin
                        r.length = 4;
                        r.field_x = {6'd0, w.byte1[5:4]};
                        r.immediate = {w.byte3, w.byte2};
                        r.flags |= F_IMM | F_ADR | F_MEM;
                    end
                end
            end
            else if (w.byte1 == OP_DD || w.byte1 == OP_FD || w.byte1 == OP_ED)
            begin
                r.op_class = C_IX;
                r.length = 1;
            end
            else if (w.byte1 == OP_CB)
            begin
                r.op_class = C_IXCB;
                r.length = 4;
                r.displacement = w.byte2;
            end
            else
            begin
                s = opcode_info(w.byte1);
                r.op_class = C_IX;
                r.length = 3'd1 + s.len;
                if (uses_hl_memory(w.byte1))
                begin
                    r.length = r.length + 3'd1;
                    r.displacement = w.byte2;
                end
            end
        end
        return r;
    endfunction

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n > 0)
        begin
            in_ch.valid <= 0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_window(in_item_t w);
        in_ch.valid <= 1;
        in_ch.data <= w;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_item(decode_window(w));
        @(negedge clk);
        idle_gap();
    endtask

    task automatic send_bytes(logic [15:0] pc, logic [7:0] b0, logic [7:0] b1,
                              logic [7:0] b2, logic [7:0] b3);
        in_item_t w;
        w.fetch_pc = pc;
        w.byte0 = b0;
        w.byte1 = b1;
        w.byte2 = b2;
        w.byte3 = b3;
        send_window(w);
    endtask

    task automatic set_hook_limit(logic [7:0] v);
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
        cfg_we <= 1;
        cfg_wdata <= v;
        exp_hook_limit = v;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic random_window();
        logic [7:0] b0;
        logic [7:0] b1;
        int sel;
        sel = $urandom_range(0, 9);
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        case (sel)
            0: b0 = OP_CB;
            1: b0 = OP_ED;
            2:
            begin
                b0 = OP_ED;
                b1 = OP_HOOK;
            end
            3: b0 = $urandom_range(0, 1) ? OP_DD : OP_FD;
            4:
            begin
                b0 = OP_ED;
                b1 = {2'b01, 2'($urandom), 4'h3} | ($urandom_range(0, 1) ? 8'h08 : 8'h00);
            end
            default: ;
        endcase
        send_bytes(16'($urandom), b0, b1, 8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        out_ch.ready = 0;
        forever
        begin
            @(negedge clk);
            if (!out_ready_en) out_ch.ready <= 1;
            else if ($urandom_range(0, 19) == 0) out_ch.ready <= 0;
            else if ($urandom_range(0, 2) == 0) out_ch.ready <= $urandom_range(0, 1);
            else out_ch.ready <= 1;
        end
    end

    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);

    initial
    begin
        int i;
        int c;
        sb = new();
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        exp_hook_limit = HOOK_LIMIT_RESET;
        out_ready_en = 0;
        in_ch.valid = 0;
        in_ch.data = '0;
        repeat (12) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send_bytes(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
        send_bytes(16'hffff, 8'hff, 8'hff, 8'hff, 8'hff);
        send_bytes(16'hfffe, 8'h18, 8'h7f, 8'h00, 8'h00);
        send_bytes(16'h0001, 8'h10, 8'h80, 8'h00, 8'h00);
        send_bytes(16'h1234, 8'h38, 8'hfe, 8'h00, 8'h00);
        send_bytes(16'h0000, 8'hc3, 8'h34, 8'h12, 8'h00);
        send_bytes(16'h0000, OP_HLT, 8'h00, 8'h00, 8'h00);
        send_bytes(16'h0000, OP_CB, 8'h7e, 8'h00, 8'h00);
        send_bytes(16'h0000, OP_ED, 8'h43, 8'hcd, 8'hab);
        send_bytes(16'h0000, OP_ED, 8'h7b, 8'hff, 8'hff);
        send_bytes(16'h0000, OP_ED, 8'hb0, 8'h00, 8'h00);
        send_bytes(16'h0000, OP_ED, OP_HOOK, 8'hff, 8'h00);
        send_bytes(16'h0000, OP_DD, OP_DD, 8'h00, 8'h00);
        send_bytes(16'h0000, OP_FD, OP_FD, 8'h00, 8'h00);
        send_bytes(16'h0000, OP_DD, OP_ED, 8'h00, 8'h00);
        send_bytes(16'h0000, OP_FD, OP_CB, 8'h80, 8'h06);
        send_bytes(16'h0000, OP_DD, 8'h36, 8'h7f, 8'h55);
        send_bytes(16'h0000, OP_DD, 8'h21, 8'h00, 8'h80);
        send_bytes(16'h0000, OP_FD, 8'h86, 8'hff, 8'h00);
        send_bytes(16'h0000, OP_DD, OP_HLT, 8'h01, 8'h00);

        set_hook_limit(8'h00);
        send_bytes(16'h0000, OP_ED, OP_HOOK, 8'h00, 8'h00);
        send_bytes(16'h0000, OP_ED, OP_HOOK, 8'h01, 8'h00);
        for (i = 0; i < 256; i++)
            send_bytes(16'($urandom), 8'(i), 8'($urandom), 8'($urandom), 8'($urandom));

        out_ready_en = 1;
        for (c = 0; c < 3; c++)
        begin
            case (c)
                0: set_hook_limit(8'hff);
                1: set_hook_limit(8'($urandom_range(1, 254)));
                default: set_hook_limit(8'h80);
            endcase
            for (i = 0; i < 70; i++) random_window();
        end

        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (!sb.failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire

@@ z80_instruction_decoder_top.f @@
+incdir+rtl
rtl/z80d_pkg.sv
rtl/z80d_if.sv
rtl/z80_instruction_decoder_top.sv
dv/tb_z80_instruction_decoder_top.sv
